// File: rtl/dgsl_pkg.sv
package dgsl_pkg;

  // Gain format: Q1.GAIN_FRAC_BITS, unity is 2^GAIN_FRAC_BITS
  localparam int unsigned GAIN_FRAC_BITS = 15;
  localparam int unsigned GAIN_W         = 16;
  localparam int unsigned SWING_W        = GAIN_FRAC_BITS + 1;
  // quotient bits kept by the divider; anything wider saturates anyway
  localparam int unsigned QUO_W          = GAIN_FRAC_BITS + 2;
  localparam int unsigned DIV_CNT_W      = $clog2(QUO_W);

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1 << GAIN_FRAC_BITS);

  // config register map
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUCK_FLOOR   = 2'd0,
    CFG_ATTACK_TIME  = 2'd1,
    CFG_RELEASE_TIME = 2'd2
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0] FLOOR_RST   = 16'd8192;
  localparam logic [31:0]       ATTACK_RST  = 32'd100000;
  localparam logic [31:0]       RELEASE_RST = 32'd500000;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIV  = 5'b01000,
    S_UPD  = 5'b10000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;   // capture dt / duration / trigger
    logic mul;       // swing * dt into product register
    logic chk;       // overflow check, seed divider
    logic div_step;  // one restoring-division bit
    logic upd;       // gain update, load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ovf;       // quotient saturates, divider can be skipped
  } dp_sts_t;

endpackage

// File: rtl/dgsl_ctrl.sv
module dgsl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  dgsl_pkg::dp_sts_t sts_i,
  output dgsl_pkg::dp_cmd_t cmd_o
);
  import dgsl_pkg::*;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 in_xfer, upd_go;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  // output register must be free (or draining this cycle) before update
  assign upd_go      = (state_q == S_UPD) && !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.load_in = in_xfer;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        cnt_d     = DIV_CNT_W'(QUO_W - 1);
        state_d   = sts_i.ovf ? S_UPD : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_go) begin
          cmd_o.upd   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/dgsl_dp.sv
module dgsl_dp #(
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config writes
  input  logic                              cfg_we_i,
  input  logic [dgsl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [TIME_BITS-1:0]              cfg_data_i,
  // input payload
  input  logic signed [TIME_BITS:0]         elapsed_us_i,
  input  logic                              duck_active_i,
  // control
  input  dgsl_pkg::dp_cmd_t                 cmd_i,
  output dgsl_pkg::dp_sts_t                 sts_o,
  output logic [dgsl_pkg::GAIN_W-1:0]       duck_gain_o
);
  import dgsl_pkg::*;

  localparam int unsigned TB   = TIME_BITS;
  localparam int unsigned NB   = SWING_W + TB;   // product width
  localparam int unsigned HI_W = NB - QUO_W;     // product bits above quotient window

  // config registers
  logic [GAIN_W-1:0] floor_q;
  logic [TB-1:0]     attack_q, release_q;

  // per-item working registers
  logic              active_q;
  logic [TB-1:0]     dt_q, dur_q;
  logic [NB-1:0]     prod_q;
  logic              ovf_q;
  logic [TB-1:0]     rem_q;
  logic [QUO_W-1:0]  low_q, quo_q;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic [GAIN_W-1:0] out_q;

  logic [GAIN_W-1:0]  fl, target, step, diff;
  logic [SWING_W-1:0] swing;
  logic [TB-1:0]      dur_sel;
  logic               ovf_d;
  logic [TB:0]        rem_sh;
  logic               rem_ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= FLOOR_RST;
      attack_q  <= TB'(ATTACK_RST);
      release_q <= TB'(RELEASE_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DUCK_FLOOR:   floor_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_ATTACK_TIME:  attack_q  <= cfg_data_i;
        CFG_RELEASE_TIME: release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fl     = (floor_q > UNITY) ? UNITY : floor_q;
  assign swing  = SWING_W'(UNITY - fl);
  assign target = active_q ? fl : UNITY;

  assign dur_sel = duck_active_i ? attack_q : release_q;

  // saturation test: quotient needs more than QUO_W bits
  assign ovf_d = {{(TB-HI_W){1'b0}}, prod_q[NB-1:QUO_W]} >= dur_q;

  // one restoring-division bit
  assign rem_sh = {rem_q, low_q[QUO_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dur_q};

  always_comb begin
    if (ovf_q || (quo_q > QUO_W'(UNITY))) begin
      step = UNITY;
    end else begin
      step = quo_q[GAIN_W-1:0];
    end
    diff = (target >= gain_q) ? (target - gain_q) : (gain_q - target);
    if (diff <= step) begin
      gain_d = target;
    end else if (target > gain_q) begin
      gain_d = gain_q + step;
    end else begin
      gain_d = gain_q - step;
    end
    if (gain_d > UNITY) begin
      gain_d = UNITY;
    end
    if (gain_d < fl) begin
      gain_d = fl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= UNITY;
    end else if (cmd_i.upd) begin
      gain_q <= gain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      active_q <= duck_active_i;
      dt_q     <= elapsed_us_i[TB] ? '0 : elapsed_us_i[TB-1:0];
      dur_q    <= (dur_sel == '0) ? TB'(1) : dur_sel;
    end
    if (cmd_i.mul) begin
      prod_q <= {{TB{1'b0}}, swing} * {{SWING_W{1'b0}}, dt_q};
    end
    if (cmd_i.chk) begin
      ovf_q <= ovf_d;
      rem_q <= {{(TB-HI_W){1'b0}}, prod_q[NB-1:QUO_W]};
      low_q <= prod_q[QUO_W-1:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? TB'(rem_sh - {1'b0, dur_q}) : rem_sh[TB-1:0];
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], rem_ge};
    end
    if (cmd_i.upd) begin
      out_q <= gain_d;
    end
  end

  assign sts_o.ovf   = ovf_d;
  assign duck_gain_o = out_q;

endmodule

// File: rtl/ducking_gain_slew_limiter_core.sv
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o elapsed_us_i, duck_active_i
// out      source     out_valid_o/out_stall_i duck_gain_o
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item passes from transfer to the next free input slot through the transfer,
// one multiply, one saturation check, 17 restoring-division steps and one update.
// When the quotient saturates the divider is skipped. The division loop yields
// one quotient bit per cycle.
// Reset (rst_ni low, async) restores gain to unity and all config registers.
// A stalled result holds in the output register while the next item computes;
// the update waits only if that register is still occupied.
module ducking_gain_slew_limiter_core #(
  parameter int unsigned TIME_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tick input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [TIME_BITS:0]           elapsed_us_i,
  input  logic                                duck_active_i,
  // gain output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dgsl_pkg::GAIN_W-1:0]         duck_gain_o,
  // config write port
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dgsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [TIME_BITS-1:0]                cfg_data_i
);
  import dgsl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Config writes are always accepted; out-of-range indexes are dropped
  // inside the datapath.
  assign cfg_ready_o = 1'b1;

  // Sequencer: idle -> multiply -> check -> divide x17 -> update; divide is skipped on saturation.
  dgsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: config registers, step = swing*dt/dur, gain register, output reg.
  dgsl_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .elapsed_us_i  (elapsed_us_i),
    .duck_active_i (duck_active_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .duck_gain_o   (duck_gain_o)
  );

endmodule

// File: rtl/dgsl_chk.sv
module dgsl_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [dgsl_pkg::GAIN_W-1:0]         duck_gain_o
);
  import dgsl_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(duck_gain_o))
    else $error("stalled result changed");

  // one item at a time: a transfer closes the input until the result is made
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input reopened right after transfer");

  // a valid gain never exceeds unity
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duck_gain_o <= UNITY)
    else $error("gain above unity");

endmodule

bind ducking_gain_slew_limiter_core dgsl_chk u_dgsl_chk (.*);
